// File: rtl/lljd_pkg.sv
package lljd_pkg;

  localparam int MODE_W     = 2;
  localparam int PIDX_W     = 4;
  localparam int VAL_W      = 16;
  localparam int LOAD_W     = 32;
  localparam int CFG_W      = 5;
  localparam int MAX_ACTIVE = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_PRESET = 2'd1,
    MODE_ASSIGN = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;    // capture request and restart the search counters
    logic step;    // search step: issue a read, compare the previous one
    logic commit;  // apply the request and load the result register
  } cmd_t;

  typedef struct packed {
    logic search_done;
    logic out_free;
  } status_t;

endpackage

// File: rtl/lljd_in_if.sv
interface lljd_in_if;
  import lljd_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [PIDX_W-1:0] proc_index;
  logic [VAL_W-1:0]  value;

  modport source (output valid, output mode, output proc_index, output value, input ready);
  modport sink   (input valid, input mode, input proc_index, input value, output ready);
endinterface

// File: rtl/lljd_out_if.sv
interface lljd_out_if;
  import lljd_pkg::*;

  logic              valid;
  logic              ready;
  logic [PIDX_W-1:0] assigned_processor;
  logic [LOAD_W-1:0] new_load;
  logic [LOAD_W-1:0] makespan;
  logic              saturated;

  modport source (output valid, output assigned_processor, output new_load,
                  output makespan, output saturated, input ready);
  modport sink   (input valid, input assigned_processor, input new_load,
                  input makespan, input saturated, output ready);
endinterface

// File: rtl/least_loaded_job_dispatcher_unit.sv
// Greedy list scheduler: keeps a load per processor and the makespan. A request
// is taken only while the unit is idle. Clear, preset and unused-mode requests
// go from IDLE straight to FINISH; an assign request first passes SEARCH,
// where the minimum over the n active processors (n from 1 to min(PROCS, 16))
// is found by reading the load memory through its single read port, one
// processor a cycle, into one shared comparator. A finished result sits in
// an output register, so the next request is accepted while it waits; that
// request completes only once the register has been taken.
module least_loaded_job_dispatcher_unit #(
  parameter int PROCS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [lljd_pkg::CFG_W-1:0]  cfg_data,
  lljd_in_if.sink                     jobs,
  lljd_out_if.source                  results
);
  import lljd_pkg::*;

  cmd_t    cmd;
  status_t status;

  lljd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (jobs.valid),
    .req_mode  (jobs.mode),
    .req_ready (jobs.ready),
    .status    (status),
    .cmd       (cmd)
  );

  lljd_datapath #(
    .PROCS (PROCS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .req_mode       (jobs.mode),
    .req_proc_index (jobs.proc_index),
    .req_value      (jobs.value),
    .cmd            (cmd),
    .status         (status),
    .rsp_valid      (results.valid),
    .rsp_ready      (results.ready),
    .rsp_proc       (results.assigned_processor),
    .rsp_load       (results.new_load),
    .rsp_makespan   (results.makespan),
    .rsp_sat        (results.saturated)
  );
endmodule

// File: rtl/lljd_ctrl.sv
module lljd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic [lljd_pkg::MODE_W-1:0] req_mode,
  output logic              req_ready,
  input  lljd_pkg::status_t status,
  output lljd_pkg::cmd_t    cmd
);
  import lljd_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load = 1'b1;
          if (mode_t'(req_mode) == MODE_ASSIGN) begin
            state_next = ST_SEARCH;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_SEARCH: begin
        if (status.search_done) begin
          state_next = ST_FINISH;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

// File: rtl/lljd_datapath.sv
module lljd_datapath #(
  parameter int PROCS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [lljd_pkg::CFG_W-1:0]  cfg_data,
  input  logic [lljd_pkg::MODE_W-1:0] req_mode,
  input  logic [lljd_pkg::PIDX_W-1:0] req_proc_index,
  input  logic [lljd_pkg::VAL_W-1:0]  req_value,
  input  lljd_pkg::cmd_t              cmd,
  output lljd_pkg::status_t           status,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output logic [lljd_pkg::PIDX_W-1:0] rsp_proc,
  output logic [lljd_pkg::LOAD_W-1:0] rsp_load,
  output logic [lljd_pkg::LOAD_W-1:0] rsp_makespan,
  output logic                        rsp_sat
);
  import lljd_pkg::*;

  localparam int IDX_W = (PROCS > 1) ? $clog2(PROCS) : 1;
  localparam int CAP   = (PROCS < MAX_ACTIVE) ? PROCS : MAX_ACTIVE;
  localparam int CNT_W = $clog2(CAP + 1);

  logic [LOAD_W-1:0] load_mem [PROCS];
  logic [PROCS-1:0]  vld;

  logic [CFG_W-1:0]  num_procs;
  logic [CNT_W-1:0]  n_act;

  logic [MODE_W-1:0] mode_q;
  logic [PIDX_W-1:0] idx_q;
  logic [VAL_W-1:0]  val_q;

  logic [CNT_W-1:0]  rd_cnt;
  logic [CNT_W-1:0]  cmp_cnt;
  logic              rd_pend;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [LOAD_W-1:0] rd_data;
  logic              rd_vld;
  logic [LOAD_W-1:0] rd_load;

  logic [PIDX_W-1:0] best_idx;
  logic [LOAD_W-1:0] best_load;
  logic [LOAD_W-1:0] makespan;

  logic              mem_we;
  logic              clr;
  logic [IDX_W-1:0]  wr_addr;
  logic [LOAD_W-1:0] wr_data;
  logic [PIDX_W-1:0] res_proc;
  logic [LOAD_W-1:0] res_load;
  logic              res_sat;
  logic [LOAD_W-1:0] makespan_next;
  logic [LOAD_W:0]   sum;
  logic              in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_procs <= CFG_W'(MAX_ACTIVE);
    end else if (cfg_we) begin
      num_procs <= cfg_data;
    end
  end

  // zero acts as one, anything past the processor count is clipped
  always_comb begin
    if (num_procs == '0) begin
      n_act = CNT_W'(1);
    end else if (num_procs > CFG_W'(CAP)) begin
      n_act = CNT_W'(CAP);
    end else begin
      n_act = CNT_W'(num_procs);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q <= req_mode;
      idx_q  <= req_proc_index;
      val_q  <= req_value;
    end
  end

  // search: reads issued one a cycle, each compared the cycle after
  assign rd_en   = cmd.step && (rd_cnt < n_act);
  assign rd_addr = IDX_W'(rd_cnt);
  assign rd_load = rd_vld ? rd_data : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else if (cmd.load) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_cnt  <= '0;
      cmp_cnt <= '0;
    end else begin
      if (rd_en) begin
        rd_cnt <= rd_cnt + CNT_W'(1);
      end
      if (rd_pend) begin
        cmp_cnt <= cmp_cnt + CNT_W'(1);
        // strict less keeps the lowest index on ties
        if (cmp_cnt == '0 || rd_load < best_load) begin
          best_load <= rd_load;
          best_idx  <= PIDX_W'(cmp_cnt);
        end
      end
    end
  end

  assign status.search_done = (cmp_cnt == n_act);
  assign status.out_free    = !rsp_valid || rsp_ready;

  assign in_range = (32'(idx_q) < PROCS);
  assign sum      = {1'b0, best_load} + {{(LOAD_W + 1 - VAL_W){1'b0}}, val_q};

  always_comb begin
    mem_we        = 1'b0;
    clr           = 1'b0;
    wr_addr       = IDX_W'(best_idx);
    wr_data       = '0;
    res_proc      = '0;
    res_load      = '0;
    res_sat       = 1'b0;
    makespan_next = makespan;
    case (mode_t'(mode_q))
      MODE_CLEAR: begin
        clr           = 1'b1;
        makespan_next = '0;
      end
      MODE_PRESET: begin
        res_proc = idx_q;
        if (in_range) begin
          mem_we   = 1'b1;
          wr_addr  = IDX_W'(idx_q);
          wr_data  = LOAD_W'(val_q);
          res_load = LOAD_W'(val_q);
          if (LOAD_W'(val_q) > makespan) begin
            makespan_next = LOAD_W'(val_q);
          end
        end
      end
      MODE_ASSIGN: begin
        mem_we   = 1'b1;
        res_proc = best_idx;
        res_sat  = sum[LOAD_W];
        res_load = sum[LOAD_W] ? '1 : sum[LOAD_W-1:0];
        wr_data  = res_load;
        if (res_load > makespan) begin
          makespan_next = res_load;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && mem_we) begin
      load_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= load_mem[rd_addr];
      rd_vld  <= vld[rd_addr];
    end
  end

  // entry valid bits stand in for zeroing the table
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (cmd.commit && clr) begin
      vld <= '0;
    end else if (cmd.commit && mem_we) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      makespan <= '0;
    end else if (cmd.commit) begin
      makespan <= makespan_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp_proc     <= res_proc;
      rsp_load     <= res_load;
      rsp_makespan <= makespan_next;
      rsp_sat      <= res_sat;
    end
  end
endmodule

// File: tb/sv/tb.sv
module tb;
  import lljd_pkg::*;

  localparam int PROC_COUNT  = 16;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE      = 24;

  typedef struct packed {
    logic [PIDX_W-1:0] cpu;
    logic [LOAD_W-1:0] load;
    logic [LOAD_W-1:0] span;
    logic              sat;
  } dispatch_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_data;

  lljd_in_if  jobs_if ();
  lljd_out_if res_if ();

  least_loaded_job_dispatcher_unit #(.PROCS(PROC_COUNT)) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .jobs     (jobs_if),
    .results  (res_if)
  );

  // scheduler shadow state
  logic [LOAD_W-1:0] proc_load [PROC_COUNT];
  logic [LOAD_W-1:0] peak_load;
  logic [CFG_W-1:0]  proc_setting;

  dispatch_t pending_dispatches[$];

  int errors       = 0;
  int cycle_count  = 0;
  int hold_len     = 0;
  bit gaps_on      = 0;
  bit stalls_on    = 0;

  always #4 clk = ~clk;

  function automatic dispatch_t predict_dispatch(mode_t m, logic [PIDX_W-1:0] idx,
                                                 logic [VAL_W-1:0] v);
    dispatch_t         r;
    int                n;
    int                best;
    logic [LOAD_W:0]   sum;
    r = '0;
    case (m)
      MODE_CLEAR: begin
        foreach (proc_load[k]) proc_load[k] = '0;
        peak_load = '0;
      end
      MODE_PRESET: begin
        r.cpu = idx;
        if (idx < PROC_COUNT) begin
          proc_load[idx] = LOAD_W'(v);
          r.load = LOAD_W'(v);
          if (LOAD_W'(v) > peak_load) peak_load = LOAD_W'(v);
        end
      end
      MODE_ASSIGN: begin
        n = (proc_setting == 0) ? 1 : int'(proc_setting);
        if (n > PROC_COUNT) n = PROC_COUNT;
        if (n > MAX_ACTIVE) n = MAX_ACTIVE;
        best = 0;
        for (int k = 1; k < n; k++)
          if (proc_load[k] < proc_load[best]) best = k;
        sum = {1'b0, proc_load[best]} + (LOAD_W + 1)'(v);
        // clip at all ones
        if (sum[LOAD_W]) begin
          r.load = '1;
          r.sat  = 1'b1;
        end else begin
          r.load = sum[LOAD_W-1:0];
        end
        proc_load[best] = r.load;
        if (r.load > peak_load) peak_load = r.load;
        r.cpu = PIDX_W'(best);
      end
      default: ;
    endcase
    r.span = peak_load;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [LOAD_W-1:0] got, logic [LOAD_W-1:0] want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycle_count);
    errors++;
  endtask

  task automatic send_job(mode_t m, logic [PIDX_W-1:0] idx, logic [VAL_W-1:0] v);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      jobs_if.valid = 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk);
    end
    @(negedge clk);
    jobs_if.valid      = 1'b1;
    jobs_if.mode       = m;
    jobs_if.proc_index = idx;
    jobs_if.value      = v;
    do @(posedge clk); while (!jobs_if.ready);
    pending_dispatches.push_back(predict_dispatch(m, idx, v));
  endtask

  task automatic wait_all_dispatched();
    @(negedge clk);
    jobs_if.valid = 1'b0;
    while (pending_dispatches.size() != 0) @(negedge clk);
  endtask

  task automatic set_processor_count(logic [CFG_W-1:0] n);
    wait_all_dispatched();
    repeat (SETTLE) @(negedge clk);
    cfg_we   = 1'b1;
    cfg_data = n;
    @(negedge clk);
    cfg_we   = 1'b0;
    proc_setting = n;
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin
    dispatch_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (pending_dispatches.size() == 0) begin
        $display("unexpected result at cycle %0d", cycle_count);
        errors++;
      end else begin
        want = pending_dispatches.pop_front();
        if (res_if.assigned_processor !== want.cpu)
          report_mismatch("assigned_processor", LOAD_W'(res_if.assigned_processor),
                          LOAD_W'(want.cpu));
        if (res_if.new_load !== want.load)
          report_mismatch("new_load", res_if.new_load, want.load);
        if (res_if.makespan !== want.span)
          report_mismatch("makespan", res_if.makespan, want.span);
        if (res_if.saturated !== want.sat)
          report_mismatch("saturated", LOAD_W'(res_if.saturated), LOAD_W'(want.sat));
      end
    end
  end

  // result-side ready, with random stalls and the long hold
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len != 0) begin
        res_if.ready = 1'b0;
        repeat (hold_len) @(negedge clk);
        hold_len = 0;
        res_if.ready = 1'b1;
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
        res_if.ready = 1'b0;
        repeat ($urandom_range(0, 4)) @(negedge clk);
      end else begin
        res_if.ready = 1'b1;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("== FAIL ==");
    $finish;
  end

  task automatic test_basic_ops();
    send_job(MODE_CLEAR, 4'd0, 16'd0);
    send_job(MODE_ASSIGN, 4'd0, 16'd10);       // all tied, lowest index wins
    send_job(MODE_ASSIGN, 4'd0, 16'd0);
    send_job(MODE_PRESET, 4'd15, 16'hFFFF);
    send_job(MODE_PRESET, 4'd0, 16'd0);
    send_job(MODE_PRESET, 4'd15, 16'd3);       // lowering does not lower the makespan
    send_job(MODE_ASSIGN, 4'd7, 16'hFFFF);
    send_job(MODE_NOP, 4'd9, 16'h1234);
    send_job(MODE_NOP, 4'd0, 16'd0);
    send_job(MODE_CLEAR, 4'd5, 16'hFFFF);
    send_job(MODE_ASSIGN, 4'd15, 16'd1);
  endtask

  task automatic test_active_counts();
    logic [CFG_W-1:0] counts [6] = '{5'd0, 5'd1, 5'd2, 5'd17, 5'd31, 5'd16};
    foreach (counts[i]) begin
      set_processor_count(counts[i]);
      send_job(MODE_CLEAR, 4'd0, 16'd0);
      send_job(MODE_ASSIGN, 4'd0, 16'd100);
      send_job(MODE_ASSIGN, 4'd0, 16'd50);
    end
  endtask

  task automatic test_backpressure();
    hold_len = 300;
    for (int i = 0; i < 12; i++)
      send_job(MODE_ASSIGN, 4'd0, pick_value());
    wait_all_dispatched();
    for (int i = 0; i < 6; i++)
      send_job(mode_t'($urandom_range(0, 3)), PIDX_W'($urandom), pick_value());
  endtask

  task automatic test_heavy_load();
    set_processor_count(5'd1);
    send_job(MODE_CLEAR, 4'd0, 16'd0);
    // one active processor takes every job, so its load keeps climbing
    for (int i = 0; i < 40; i++)
      send_job(MODE_ASSIGN, 4'd0, 16'hFFFF);
    send_job(MODE_ASSIGN, 4'd0, 16'd0);
    send_job(MODE_ASSIGN, 4'd0, 16'd1);
    send_job(MODE_PRESET, 4'd0, 16'd7);
    send_job(MODE_ASSIGN, 4'd0, 16'd1);
  endtask

  task automatic test_random();
    logic [CFG_W-1:0] setting;
    mode_t            m;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       setting = 5'd16;
        1:       setting = 5'd1;
        2:       setting = 5'd0;
        3:       setting = 5'd31;
        default: setting = CFG_W'($urandom_range(2, 15));
      endcase
      set_processor_count(setting);
      if (phase == 5) begin
        gaps_on   = 0;
        stalls_on = 0;
      end
      for (int i = 0; i < 280; i++) begin
        case ($urandom_range(0, 19))
          0:          m = MODE_CLEAR;
          1:          m = MODE_NOP;
          2, 3, 4, 5: m = MODE_PRESET;
          default:    m = MODE_ASSIGN;
        endcase
        send_job(m, PIDX_W'($urandom), pick_value());
      end
    end
  endtask

  initial begin
    clk                = 1'b0;
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_data           = '0;
    jobs_if.valid      = 1'b0;
    jobs_if.mode       = MODE_CLEAR;
    jobs_if.proc_index = '0;
    jobs_if.value      = '0;
    foreach (proc_load[k]) proc_load[k] = '0;
    peak_load    = '0;
    proc_setting = 5'd16;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    gaps_on   = 1;
    stalls_on = 1;
    test_basic_ops();
    test_active_counts();
    test_backpressure();
    gaps_on   = 0;
    stalls_on = 0;
    test_heavy_load();
    gaps_on   = 1;
    stalls_on = 1;
    test_random();

    wait_all_dispatched();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: least_loaded_job_dispatcher_unit.f
rtl/lljd_pkg.sv
rtl/lljd_in_if.sv
rtl/lljd_out_if.sv
rtl/lljd_ctrl.sv
rtl/lljd_datapath.sv
rtl/least_loaded_job_dispatcher_unit.sv
tb/sv/tb.sv
